// ----- hdl/bsb_pkg.sv -----
// Shared types and constants for the buddy status bitmap.
// No dependencies; every other file of the block imports this package.
package bsb_pkg;

  // Default tree geometry
  localparam int unsigned TOP_LEVEL_DEF       = 10;
  localparam int unsigned MIN_BLOCK_SHIFT_DEF = 4;

  // Fixed field widths
  localparam int unsigned OPCODE_W  = 2;
  localparam int unsigned LEVEL_W   = 4;
  localparam int unsigned INDEX_W   = 10;
  localparam int unsigned OFFSET_W  = 14;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned BIT_SEL_W = 5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_GET  = 2'd0,
    OP_SET  = 2'd1,
    OP_FIND = 2'd2
  } opcode_e;

  // Class of an incoming word after range checks
  typedef enum logic [1:0] {
    KIND_NODE = 2'd0,
    KIND_FIND = 2'd1,
    KIND_BAD  = 2'd2
  } kind_e;

  // Controller -> datapath
  typedef struct packed {
    logic clr_we;
    logic load;
    logic node_rd;
    logic node_mod;
    logic find_step;
    logic res_hit;
    logic out_load;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic  clr_last;
    kind_e in_kind;
    logic  find_hit;
    logic  find_end;
    logic  out_free;
  } status_t;

endpackage

// ----- hdl/bsb_req_if.sv -----
// Request channel of the buddy status bitmap: valid/ready plus request fields.
// Depends on bsb_pkg for field widths.
interface bsb_req_if;
  import bsb_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [LEVEL_W-1:0]  tree_level;
  logic [INDEX_W-1:0]  node_index;
  logic                write_value;
  logic [OFFSET_W-1:0] byte_offset;

  modport source (
    output valid, opcode, tree_level, node_index, write_value, byte_offset,
    input  ready
  );
  modport sink (
    input  valid, opcode, tree_level, node_index, write_value, byte_offset,
    output ready
  );
endinterface

// ----- hdl/bsb_rsp_if.sv -----
// Response channel of the buddy status bitmap: valid/ready plus result fields.
// Depends on bsb_pkg for field widths.
interface bsb_rsp_if;
  import bsb_pkg::*;

  logic               valid;
  logic               ready;
  logic               node_bit;
  logic               found;
  logic [LEVEL_W-1:0] found_level;
  logic               bad_request;

  modport source (
    output valid, node_bit, found, found_level, bad_request,
    input  ready
  );
  modport sink (
    input  valid, node_bit, found, found_level, bad_request,
    output ready
  );
endinterface

// ----- hdl/buddy_status_bitmap.sv -----
// Buddy status bitmap: get/set one node bit, or find the allocated level of an offset.
// Accept to response valid: get/set pass S_NODE_RD, S_NODE_MOD, S_RESP; a rejected word
// goes to S_RESP; find walks down from the level in use to a hit or past level 0. S_RESP
// waits for a free output. Next word taken the cycle after the response is loaded.
// The find walk reads at most one word per level, at aligned levels. Reset: async active
// low; then a clearing pass zeroes every status word while req_i.ready stays low.
module buddy_status_bitmap #(
  parameter int unsigned TOP_LEVEL       = bsb_pkg::TOP_LEVEL_DEF,
  parameter int unsigned MIN_BLOCK_SHIFT = bsb_pkg::MIN_BLOCK_SHIFT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bsb_req_if.sink                     req_i,
  bsb_rsp_if.source                   rsp_o,
  input  logic                        cfg_we_i,
  input  logic [bsb_pkg::LEVEL_W-1:0] cfg_wdata_i
);
  import bsb_pkg::*;

  // Controller and datapath talk only through these two structs.
  cmd_t    cmd;
  status_t status;

  // Controller: clear sweep, then one request word at a time.
  bsb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: config register, bitmap memory (registered read), find walk,
  // and the output register that holds a finished response word.
  bsb_datapath #(
    .TOP_LEVEL       (TOP_LEVEL),
    .MIN_BLOCK_SHIFT (MIN_BLOCK_SHIFT)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .opcode_i          (req_i.opcode),
    .tree_level_i      (req_i.tree_level),
    .node_index_i      (req_i.node_index),
    .write_value_i     (req_i.write_value),
    .byte_offset_i     (req_i.byte_offset),
    .cmd_i             (cmd),
    .status_o          (status),
    .rsp_valid_o       (rsp_o.valid),
    .rsp_ready_i       (rsp_o.ready),
    .rsp_node_bit_o    (rsp_o.node_bit),
    .rsp_found_o       (rsp_o.found),
    .rsp_found_level_o (rsp_o.found_level),
    .rsp_bad_request_o (rsp_o.bad_request)
  );

endmodule

// ----- hdl/bsb_ctrl.sv -----
// Sequencing FSM of the buddy status bitmap: clear pass, get/set, find walk.
// Depends on bsb_pkg (cmd_t, status_t, kind_e).
module bsb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  bsb_pkg::status_t  status_i,
  output bsb_pkg::cmd_t     cmd_o
);
  import bsb_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR    = 6'b000001,
    S_IDLE     = 6'b000010,
    S_NODE_RD  = 6'b000100,
    S_NODE_MOD = 6'b001000,
    S_FIND     = 6'b010000,
    S_RESP     = 6'b100000
  } state_e;

  state_e state_q, state_d;

  assign req_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (status_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          unique case (status_i.in_kind)
            KIND_NODE: state_d = S_NODE_RD;
            KIND_FIND: state_d = S_FIND;
            default:   state_d = S_RESP;
          endcase
        end
      end
      S_NODE_RD: begin
        cmd_o.node_rd = 1'b1;
        state_d       = S_NODE_MOD;
      end
      S_NODE_MOD: begin
        cmd_o.node_mod = 1'b1;
        state_d        = S_RESP;
      end
      S_FIND: begin
        if (status_i.find_hit) begin
          cmd_o.res_hit = 1'b1;
          state_d       = S_RESP;
        end else if (status_i.find_end) begin
          state_d = S_RESP;
        end else begin
          cmd_o.find_step = 1'b1;
        end
      end
      S_RESP: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hdl/bsb_datapath.sv -----
// Datapath of the buddy status bitmap: config register, status memory,
// position arithmetic, find walk registers and output register. Uses bsb_pkg.
module bsb_datapath #(
  parameter int unsigned TOP_LEVEL       = bsb_pkg::TOP_LEVEL_DEF,
  parameter int unsigned MIN_BLOCK_SHIFT = bsb_pkg::MIN_BLOCK_SHIFT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bsb_pkg::LEVEL_W-1:0]  cfg_wdata_i,
  input  logic [bsb_pkg::OPCODE_W-1:0] opcode_i,
  input  logic [bsb_pkg::LEVEL_W-1:0]  tree_level_i,
  input  logic [bsb_pkg::INDEX_W-1:0]  node_index_i,
  input  logic                         write_value_i,
  input  logic [bsb_pkg::OFFSET_W-1:0] byte_offset_i,
  input  bsb_pkg::cmd_t                cmd_i,
  output bsb_pkg::status_t             status_o,
  output logic                         rsp_valid_o,
  input  logic                         rsp_ready_i,
  output logic                         rsp_node_bit_o,
  output logic                         rsp_found_o,
  output logic [bsb_pkg::LEVEL_W-1:0]  rsp_found_level_o,
  output logic                         rsp_bad_request_o
);
  import bsb_pkg::*;

  localparam int unsigned POS_W        = (TOP_LEVEL + 1 > 5) ? TOP_LEVEL + 1 : 5;
  localparam int unsigned STATUS_WORDS = ((1 << (TOP_LEVEL + 1)) + 31) >> 5;
  localparam int unsigned AW           = (STATUS_WORDS > 1) ? $clog2(STATUS_WORDS) : 1;
  localparam int unsigned LEVEL_MAX    = (1 << LEVEL_W) - 1;
  localparam int unsigned TOP_CAP      = (TOP_LEVEL > LEVEL_MAX) ? LEVEL_MAX : TOP_LEVEL;

  // ---------------- config
  logic [LEVEL_W-1:0] cfg_top_q;
  logic [LEVEL_W-1:0] top_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_top_q <= LEVEL_W'(TOP_CAP);
    end else if (cfg_we_i) begin
      cfg_top_q <= cfg_wdata_i;
    end
  end

  assign top_eff = (cfg_top_q > LEVEL_W'(TOP_CAP)) ? LEVEL_W'(TOP_CAP) : cfg_top_q;

  // ---------------- request decode
  logic [OFFSET_W-1:0] units_in;
  logic                in_tree;
  logic                find_bad;
  logic [POS_W-1:0]    node_mask;
  logic [POS_W-1:0]    node_pos;
  kind_e               in_kind;

  assign units_in = byte_offset_i >> MIN_BLOCK_SHIFT;
  assign in_tree  = (tree_level_i <= top_eff) &&
                    ((node_index_i >> (top_eff - tree_level_i)) == '0);
  assign find_bad = (units_in >> top_eff) != '0;

  assign node_mask = (POS_W'(1) << tree_level_i) - POS_W'(1);
  assign node_pos  = (POS_W'(node_index_i) << ({1'b0, tree_level_i} + 5'd1)) | node_mask;

  always_comb begin
    unique case (opcode_i) inside
      OP_GET, OP_SET: in_kind = in_tree ? KIND_NODE : KIND_BAD;
      OP_FIND:        in_kind = find_bad ? KIND_BAD : KIND_FIND;
      default:        in_kind = KIND_BAD;
    endcase
  end

  // ---------------- request registers
  logic                 is_set_q;
  logic                 wv_q;
  logic [AW-1:0]        addr_q;
  logic [BIT_SEL_W-1:0] bit_q;
  logic [OFFSET_W-1:0]  units_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      is_set_q <= (opcode_i == OP_SET);
      wv_q     <= write_value_i;
      addr_q   <= AW'(node_pos >> BIT_SEL_W);
      bit_q    <= node_pos[BIT_SEL_W-1:0];
      units_q  <= units_in;
    end
  end

  // ---------------- find walk
  logic [LEVEL_W-1:0]   cur_q;
  logic                 exh_q;
  logic                 pend_q;
  logic [LEVEL_W-1:0]   pend_lvl_q;
  logic [BIT_SEL_W-1:0] pend_bit_q;
  logic [POS_W-1:0]     find_mask;
  logic [POS_W-1:0]     find_pos;
  logic                 aligned;
  logic                 find_issue;

  assign find_mask  = (POS_W'(1) << cur_q) - POS_W'(1);
  assign aligned    = (POS_W'(units_q) & find_mask) == '0;
  // left-child chain: index units>>l at level l sits at (units & ~mask)<<1 | mask
  assign find_pos   = ((POS_W'(units_q) & ~find_mask) << 1) | find_mask;
  assign find_issue = cmd_i.find_step && !exh_q && aligned;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= '0;
      exh_q  <= 1'b0;
      pend_q <= 1'b0;
    end else if (cmd_i.load) begin
      cur_q  <= top_eff;
      exh_q  <= 1'b0;
      pend_q <= 1'b0;
    end else if (cmd_i.find_step) begin
      cur_q  <= cur_q - LEVEL_W'(1);
      exh_q  <= exh_q || (cur_q == '0);
      pend_q <= !exh_q && aligned;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.find_step) begin
      pend_lvl_q <= cur_q;
      pend_bit_q <= find_pos[BIT_SEL_W-1:0];
    end
  end

  // ---------------- status memory
  logic [WORD_W-1:0] status_mem_q [STATUS_WORDS];
  logic [WORD_W-1:0] rdata_q;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [AW-1:0]     clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_we) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = (rdata_q & ~(WORD_W'(1) << bit_q)) | (WORD_W'(wv_q) << bit_q);
    if (cmd_i.clr_we) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (cmd_i.node_mod && is_set_q) begin
      mem_we = 1'b1;
    end
  end

  assign mem_re    = cmd_i.node_rd || find_issue;
  assign mem_raddr = cmd_i.node_rd ? addr_q : AW'(find_pos >> BIT_SEL_W);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      status_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= status_mem_q[mem_raddr];
    end
  end

  // ---------------- result and output register
  logic               res_nbit_q;
  logic               res_found_q;
  logic [LEVEL_W-1:0] res_level_q;
  logic               res_bad_q;
  logic               out_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_nbit_q  <= 1'b0;
      res_found_q <= 1'b0;
      res_level_q <= '0;
      res_bad_q   <= (in_kind == KIND_BAD);
    end else begin
      if (cmd_i.node_mod && !is_set_q) begin
        res_nbit_q <= rdata_q[bit_q];
      end
      if (cmd_i.res_hit) begin
        res_found_q <= 1'b1;
        res_level_q <= pend_lvl_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rsp_node_bit_o    <= res_nbit_q;
      rsp_found_o       <= res_found_q;
      rsp_found_level_o <= res_level_q;
      rsp_bad_request_o <= res_bad_q;
    end
  end

  assign rsp_valid_o = out_valid_q;

  // ---------------- status to controller
  assign status_o.clr_last = (clr_q == AW'(STATUS_WORDS - 1));
  assign status_o.in_kind  = in_kind;
  assign status_o.find_hit = pend_q && rdata_q[pend_bit_q];
  assign status_o.find_end = exh_q;
  assign status_o.out_free = !out_valid_q || rsp_ready_i;

endmodule

// ----- hdl/bsb_checker.sv -----
// Port-level checks for the buddy status bitmap, bound onto the top level.
// Depends on bsb_pkg and buddy_status_bitmap.
module bsb_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_valid_i,
  input logic                        req_ready_i,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input logic                        rsp_node_bit_i,
  input logic                        rsp_found_i,
  input logic [bsb_pkg::LEVEL_W-1:0] rsp_found_level_i,
  input logic                        rsp_bad_request_i
);
  import bsb_pkg::*;

  // Held response word stays put until taken.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_node_bit_i) &&
      $stable(rsp_found_i) && $stable(rsp_found_level_i) && $stable(rsp_bad_request_i))
    else $error("response word changed while stalled");

  // One word in flight: busy straight after an accept.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while previous word still in flight");

  // A rejected request carries no other result.
  a_bad_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_bad_request_i |->
      !rsp_node_bit_i && !rsp_found_i && (rsp_found_level_i == '0))
    else $error("bad request response carries a result");

  // Get and find results never mix; level only reported when found.
  a_result_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !(rsp_node_bit_i && rsp_found_i) &&
      (rsp_found_i || (rsp_found_level_i == '0)))
    else $error("inconsistent response fields");

endmodule

bind buddy_status_bitmap bsb_checker u_bsb_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_node_bit_i    (rsp_o.node_bit),
  .rsp_found_i       (rsp_o.found),
  .rsp_found_level_i (rsp_o.found_level),
  .rsp_bad_request_i (rsp_o.bad_request)
);
